// File: sv/dmx_rfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmx_rfl_pkg: shared types and helpers for the DMX range lookup unit
// Payload structs, item and status codes, FSM states, range compare helpers.
// ----------------------------------------------------------------------------
package dmx_rfl_pkg;

    localparam int MaxFunctionsDef = 32;
    localparam int MaxSetsDef      = 256;
    localparam int ValW            = 24;

    localparam logic [1:0] KIND_FUNC   = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_NOFUNC = 2'd2;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ValW-1:0] start_value;
        logic [ValW-1:0] lookup_value;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic       function_found;
        logic [4:0] function_index;
        logic       set_found;
        logic [7:0] set_index;
    } t_out;

    // lookup token walking down the function cells
    typedef struct packed {
        logic            valid;
        logic            found;
        logic [ValW-1:0] v;
        logic [ValW-1:0] fend;
    } t_tok;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FWALK,
        S_SLOAD,
        S_SCMP,
        S_DONE
    } t_state;

    function automatic logic [ValW-1:0] full_scale(input logic [1:0] bytes);
        logic [ValW-1:0] fs;
        case (bytes)
            2'd1:    fs = 24'h0000ff;
            2'd2:    fs = 24'h00ffff;
            2'd3:    fs = 24'hffffff;
            default: fs = 24'h000000;
        endcase
        return fs;
    endfunction

    // half-open range, all-ones values also match the inclusive end
    function automatic logic holds(input logic [ValW-1:0] v,
                                   input logic [ValW-1:0] lo,
                                   input logic [ValW-1:0] hi);
        logic ones;
        ones = (v == 24'h0000ff) || (v == 24'h00ffff) || (v == 24'hffffff);
        return (v >= lo) && (ones ? (v <= hi) : (v < hi));
    endfunction

endpackage
`default_nettype wire

// File: sv/dmx_rfl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmx_rfl_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dmx_rfl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: sv/dmx_rfl_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmx_rfl_cell: one function entry of the lookup chain
// Holds one function start and its first set index; checks the passing
// lookup token against its range and hands the token to the next cell.
// ----------------------------------------------------------------------------
module dmx_rfl_cell #(
    parameter int IDX = 0,
    parameter int FCW = 6,
    parameter int FIW = 5,
    parameter int SCW = 9
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // store write
    input  wire logic                              i_wr_en,
    input  wire logic [dmx_rfl_pkg::ValW-1:0]      i_wr_start,
    input  wire logic [SCW-1:0]                    i_wr_first,
    // table context
    input  wire logic [FCW-1:0]                    i_func_total,
    input  wire logic [SCW-1:0]                    i_set_total,
    input  wire logic [dmx_rfl_pkg::ValW-1:0]      i_fs,
    input  wire logic [dmx_rfl_pkg::ValW-1:0]      i_nxt_start,
    input  wire logic [SCW-1:0]                    i_nxt_first,
    // token from previous cell
    input  wire dmx_rfl_pkg::t_tok                 i_tok,
    input  wire logic [FIW-1:0]                    i_fidx,
    input  wire logic [SCW-1:0]                    i_first,
    input  wire logic [SCW-1:0]                    i_last,
    // token to next cell
    output dmx_rfl_pkg::t_tok                      o_tok,
    output logic      [FIW-1:0]                    o_fidx,
    output logic      [SCW-1:0]                    o_first,
    output logic      [SCW-1:0]                    o_last,
    // own entry, seen by the previous cell
    output logic      [dmx_rfl_pkg::ValW-1:0]      o_start,
    output logic      [SCW-1:0]                    o_first_set
);

    localparam logic [FCW-1:0] IdxC   = FCW'(IDX);
    localparam logic [FCW-1:0] IdxP1C = FCW'(IDX + 1);
    localparam logic [FIW-1:0] IdxF   = FIW'(IDX);

    logic [dmx_rfl_pkg::ValW-1:0] r_start;
    logic [SCW-1:0]               r_first;

    logic                         w_used;
    logic                         w_has_next;
    logic [dmx_rfl_pkg::ValW-1:0] w_fend;
    logic                         w_hit;

    assign w_used     = (i_func_total >= IdxP1C);
    assign w_has_next = (i_func_total > IdxP1C);
    assign w_fend     = w_has_next ? i_nxt_start : i_fs;
    assign w_hit      = i_tok.valid && !i_tok.found && w_used
                        && dmx_rfl_pkg::holds(i_tok.v, r_start, w_fend);

    assign o_start     = r_start;
    assign o_first_set = r_first;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_func_total == IdxC)) begin
            r_start <= i_wr_start;
            r_first <= i_wr_first;
        end
    end

    // only the valid bit is reset; the rest of the token rides along
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tok.valid <= 1'b0;
        end else begin
            o_tok.valid <= i_tok.valid;
        end
        o_tok.v <= i_tok.v;
        if (w_hit) begin
            o_tok.found <= 1'b1;
            o_tok.fend  <= w_fend;
            o_fidx      <= IdxF;
            o_first     <= r_first;
            o_last      <= w_has_next ? i_nxt_first : i_set_total;
        end else begin
            o_tok.found <= i_tok.found;
            o_tok.fend  <= i_tok.fend;
            o_fidx      <= i_fidx;
            o_first     <= i_first;
            o_last      <= i_last;
        end
    end

endmodule
`default_nettype wire

// File: sv/dmx_range_function_lookup_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmx_range_function_lookup_unit: DMX channel function / set range decoder
// Two-level range table: function starts in a chain of cells, set starts in
// a RAM, one item in flight at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item per beat: load a
//   function start, load a set start under the latest function, or look up a
//   value. Every item yields exactly one result beat on the output channel
//   (o_out_valid / i_out_stall). i_cfg_we with i_cfg_wdata writes the channel
//   byte count, which sets full scale (0xff, 0xffff or 0xffffff).
//   Loads and unused kinds: the item goes straight to S_DONE, skipping the walk.
//   Lookups: the token walks MAX_FUNCTIONS cells, one per cycle, then the sets
//   of the matched function are read from the set RAM one per cycle (S_SLOAD,
//   then S_SCMP) until a set matches or the last set is passed; the set scan
//   is skipped when no function matched or the function has no sets.
//   The next item is taken the cycle after the result lands in the output
//   register; input stall is high while an item is at work.
//   A stalled result holds; a finished item waits until the output register
//   frees. Reset empties both tables (counts to zero) and sets one byte per
//   channel value; the stores themselves are not cleared.
// ----------------------------------------------------------------------------
module dmx_range_function_lookup_unit #(
    parameter int MAX_FUNCTIONS = dmx_rfl_pkg::MaxFunctionsDef,
    parameter int MAX_SETS      = dmx_rfl_pkg::MaxSetsDef
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire dmx_rfl_pkg::t_in  i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output dmx_rfl_pkg::t_out      o_out
);

    localparam int FCW = $clog2(MAX_FUNCTIONS + 1);
    localparam int FIW = $clog2(MAX_FUNCTIONS);
    localparam int SCW = $clog2(MAX_SETS + 1);
    localparam int SAW = $clog2(MAX_SETS);
    localparam int VW  = dmx_rfl_pkg::ValW;

    localparam logic [FCW-1:0] FuncMax = FCW'(MAX_FUNCTIONS);
    localparam logic [SCW-1:0] SetMax  = SCW'(MAX_SETS);

    dmx_rfl_pkg::t_state r_state, n_state;

    logic [1:0]     r_chan_bytes;
    logic [FCW-1:0] r_func_total;
    logic [SCW-1:0] r_set_total;

    logic [1:0]     r_status;
    logic           r_ffound;
    logic [FIW-1:0] r_fidx;
    logic           r_sfound;
    logic [SAW-1:0] r_sidx;
    logic [VW-1:0]  r_v;
    logic [VW-1:0]  r_fend;
    logic [VW-1:0]  r_cur;
    logic [SCW-1:0] r_k;
    logic [SCW-1:0] r_last;
    logic           r_out_valid;
    dmx_rfl_pkg::t_out r_out;

    logic           w_accept;
    logic           w_func_ok;
    logic           w_set_ok;
    logic [VW-1:0]  w_fs;
    logic [SCW-1:0] w_kp1;
    logic [SCW-1:0] w_kp2;
    logic           w_has_nxt;
    logic [VW-1:0]  w_send;
    logic           w_shit;
    logic           w_out_load;
    logic           w_chain_done;
    logic           w_walk_sets;
    logic [SAW-1:0] w_raddr;
    logic [VW-1:0]  w_rdata;
    logic [FIW+4:0] w_fidx_ext;
    logic [SAW+7:0] w_sidx_ext;

    dmx_rfl_pkg::t_tok w_tok   [MAX_FUNCTIONS+1];
    logic [FIW-1:0]    w_fidx  [MAX_FUNCTIONS+1];
    logic [SCW-1:0]    w_first [MAX_FUNCTIONS+1];
    logic [SCW-1:0]    w_lastv [MAX_FUNCTIONS+1];
    logic [VW-1:0]     w_cstart[MAX_FUNCTIONS];
    logic [SCW-1:0]    w_cfirst[MAX_FUNCTIONS];
    logic [MAX_FUNCTIONS-1:0] w_tok_vld;

    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_func_ok = (r_func_total < FuncMax);
    assign w_set_ok  = (r_func_total != '0) && (r_set_total < SetMax);
    assign w_fs      = dmx_rfl_pkg::full_scale(r_chan_bytes);

    // ---------------- function cell chain ----------------
    assign w_tok[0].valid = w_accept && (i_in.kind == dmx_rfl_pkg::KIND_LOOKUP);
    assign w_tok[0].found = 1'b0;
    assign w_tok[0].v     = i_in.lookup_value;
    assign w_tok[0].fend  = '0;
    assign w_fidx[0]      = '0;
    assign w_first[0]     = '0;
    assign w_lastv[0]     = '0;

    for (genvar g = 0; g < MAX_FUNCTIONS; g++) begin : g_cell
        logic [VW-1:0]  w_nstart;
        logic [SCW-1:0] w_nfirst;
        if (g == MAX_FUNCTIONS - 1) begin : g_tail
            assign w_nstart = '0;
            assign w_nfirst = '0;
        end else begin : g_mid
            assign w_nstart = w_cstart[g+1];
            assign w_nfirst = w_cfirst[g+1];
        end
        assign w_tok_vld[g] = w_tok[g+1].valid;

        dmx_rfl_cell #(
            .IDX (g),
            .FCW (FCW),
            .FIW (FIW),
            .SCW (SCW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_wr_en      (w_accept && (i_in.kind == dmx_rfl_pkg::KIND_FUNC)
                           && w_func_ok),
            .i_wr_start   (i_in.start_value),
            .i_wr_first   (r_set_total),
            .i_func_total (r_func_total),
            .i_set_total  (r_set_total),
            .i_fs         (w_fs),
            .i_nxt_start  (w_nstart),
            .i_nxt_first  (w_nfirst),
            .i_tok        (w_tok[g]),
            .i_fidx       (w_fidx[g]),
            .i_first      (w_first[g]),
            .i_last       (w_lastv[g]),
            .o_tok        (w_tok[g+1]),
            .o_fidx       (w_fidx[g+1]),
            .o_first      (w_first[g+1]),
            .o_last       (w_lastv[g+1]),
            .o_start      (w_cstart[g]),
            .o_first_set  (w_cfirst[g])
        );
    end

    assign w_chain_done = w_tok[MAX_FUNCTIONS].valid;
    assign w_walk_sets  = w_tok[MAX_FUNCTIONS].found
                          && (w_first[MAX_FUNCTIONS] < w_lastv[MAX_FUNCTIONS]);

    // ---------------- set start RAM ----------------
    dmx_rfl_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_in.kind == dmx_rfl_pkg::KIND_SET) && w_set_ok),
        .i_waddr (r_set_total[SAW-1:0]),
        .i_wdata (i_in.start_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // set scan: r_cur holds start of set k, w_rdata holds start of set k+1
    assign w_kp1     = r_k + SCW'(1);
    assign w_kp2     = r_k + SCW'(2);
    assign w_has_nxt = (w_kp1 < r_last);
    assign w_send    = w_has_nxt ? w_rdata : r_fend;
    assign w_shit    = dmx_rfl_pkg::holds(r_v, r_cur, w_send);

    // ---------------- FSM ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            dmx_rfl_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in.kind == dmx_rfl_pkg::KIND_LOOKUP)
                              ? dmx_rfl_pkg::S_FWALK : dmx_rfl_pkg::S_DONE;
                end
            end
            dmx_rfl_pkg::S_FWALK: begin
                if (w_chain_done) begin
                    n_state = w_walk_sets ? dmx_rfl_pkg::S_SLOAD
                                          : dmx_rfl_pkg::S_DONE;
                end
            end
            dmx_rfl_pkg::S_SLOAD: begin
                n_state = dmx_rfl_pkg::S_SCMP;
            end
            dmx_rfl_pkg::S_SCMP: begin
                if (w_shit || !w_has_nxt) begin
                    n_state = dmx_rfl_pkg::S_DONE;
                end
            end
            dmx_rfl_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = dmx_rfl_pkg::S_IDLE;
                end
            end
            default: n_state = dmx_rfl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_out_load = 1'b0;
        w_raddr    = w_kp2[SAW-1:0];
        case (r_state)
            dmx_rfl_pkg::S_IDLE:  o_in_stall = 1'b0;
            dmx_rfl_pkg::S_FWALK: w_raddr = w_first[MAX_FUNCTIONS][SAW-1:0];
            dmx_rfl_pkg::S_SLOAD: w_raddr = w_kp1[SAW-1:0];
            dmx_rfl_pkg::S_SCMP:  w_raddr = w_kp2[SAW-1:0];
            dmx_rfl_pkg::S_DONE:  w_out_load = !r_out_valid || !i_out_stall;
            default:              o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dmx_rfl_pkg::S_IDLE;
            r_chan_bytes <= 2'd1;
            r_func_total <= '0;
            r_set_total  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_chan_bytes <= i_cfg_wdata;
            end
            if (w_accept && (i_in.kind == dmx_rfl_pkg::KIND_FUNC) && w_func_ok) begin
                r_func_total <= r_func_total + FCW'(1);
            end
            if (w_accept && (i_in.kind == dmx_rfl_pkg::KIND_SET) && w_set_ok) begin
                r_set_total <= r_set_total + SCW'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result and scan registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            dmx_rfl_pkg::S_IDLE: begin
                r_ffound <= 1'b0;
                r_fidx   <= '0;
                r_sfound <= 1'b0;
                r_sidx   <= '0;
                if (i_in.kind == dmx_rfl_pkg::KIND_FUNC && !w_func_ok) begin
                    r_status <= dmx_rfl_pkg::STATUS_FULL;
                end else if (i_in.kind == dmx_rfl_pkg::KIND_SET && r_func_total == '0) begin
                    r_status <= dmx_rfl_pkg::STATUS_NOFUNC;
                end else if (i_in.kind == dmx_rfl_pkg::KIND_SET && !w_set_ok) begin
                    r_status <= dmx_rfl_pkg::STATUS_FULL;
                end else begin
                    r_status <= dmx_rfl_pkg::STATUS_OK;
                end
            end
            dmx_rfl_pkg::S_FWALK: begin
                r_ffound <= w_tok[MAX_FUNCTIONS].found;
                r_fidx   <= w_fidx[MAX_FUNCTIONS];
                r_v      <= w_tok[MAX_FUNCTIONS].v;
                r_fend   <= w_tok[MAX_FUNCTIONS].fend;
                r_k      <= w_first[MAX_FUNCTIONS];
                r_last   <= w_lastv[MAX_FUNCTIONS];
            end
            dmx_rfl_pkg::S_SLOAD: begin
                r_cur <= w_rdata;
            end
            dmx_rfl_pkg::S_SCMP: begin
                if (w_shit) begin
                    r_sfound <= 1'b1;
                    r_sidx   <= r_k[SAW-1:0];
                end else if (w_has_nxt) begin
                    r_k   <= w_kp1;
                    r_cur <= w_rdata;
                end
            end
            dmx_rfl_pkg::S_DONE: begin
                r_status <= r_status;
            end
            default: begin
                r_status <= r_status;
            end
        endcase
    end

    assign w_fidx_ext = {5'b0, r_fidx};
    assign w_sidx_ext = {8'b0, r_sidx};

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.status         <= r_status;
            r_out.function_found <= r_ffound;
            r_out.function_index <= w_fidx_ext[4:0];
            r_out.set_found      <= r_sfound;
            r_out.set_index      <= w_sidx_ext[7:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------- assertions ----------------
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vld))
        else $error("more than one lookup token in the function chain");

    a_token_only_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tok_vld != '0) |-> (r_state == dmx_rfl_pkg::S_FWALK))
        else $error("lookup token in chain outside the function walk");

    a_func_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_func_total <= FuncMax) && (r_set_total <= SetMax))
        else $error("table count beyond capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dmx_rfl_pkg::S_SCMP) |-> (r_k < r_last))
        else $error("set scan past the function's last set");

    a_set_needs_func: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.set_found) |-> r_out.function_found)
        else $error("set match reported without a function match");

    a_load_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != dmx_rfl_pkg::STATUS_OK))
        |-> !r_out.function_found)
        else $error("dropped load beat reports a match");

endmodule
`default_nettype wire
